// ----- rtl/psbf_pkg.sv -----
// Package with the shared types and constants of the pixel stream brightness fader.
`default_nettype none

package psbf_pkg;

  // Default widths for the top-level parameters.
  localparam int unsigned LevelFracBitsDefault = 15;
  localparam int unsigned LengthBitsDefault    = 16;

  // Fixed widths of the beat fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyW    = 3;
  localparam int unsigned TargetW = 16;
  localparam int unsigned RateW   = 9;
  localparam int unsigned BaseW   = 8;

  // Reset value of the base frame rate register.
  localparam logic [BaseW-1:0] BaseRateReset = 8'd30;

  // Input beat kinds.
  localparam logic ModeStream = 1'b0;
  localparam logic ModeKey    = 1'b1;

  // Result beat kinds.
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Remote key codes.
  typedef enum logic [KeyW-1:0] {
    KEY_OFF      = 3'd0,
    KEY_ON       = 3'd1,
    KEY_RESET    = 3'd2,
    KEY_FASTER   = 3'd3,
    KEY_SLOWER   = 3'd4,
    KEY_BRIGHTER = 3'd5,
    KEY_DIMMER   = 3'd6,
    KEY_OTHER    = 3'd7
  } key_e;

  // Position within a frame: four header bytes, then the data bytes.
  typedef enum logic [2:0] {
    HDR_CHAN   = 3'd0,
    HDR_CMD    = 3'd1,
    HDR_LEN_HI = 3'd2,
    HDR_LEN_LO = 3'd3,
    HDR_DATA   = 3'd4
  } phase_e;

  // One result beat as it travels through the output stages.
  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   data;
    logic               frame_end;
    logic [TargetW-1:0] target;
    logic [RateW-1:0]   rate;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/pixel_stream_brightness_fader.sv -----
// Top level of the pixel stream brightness fader.
//
// Input channel (in_valid_i/in_ready_o): each beat is either a stream byte
// (mode 0) or a remote key event (mode 1). Frames are a four-byte header
// (channel, command, length high, length low) followed by the data bytes.
// Frames with a zero command are forwarded with every data byte scaled by
// the fade level; other frames are dropped. Each key beat gives one status
// beat carrying the target level and the current frame rate.
// Output channel (out_valid_o/out_ready_i): one result beat per key event
// and one per forwarded stream byte. A key status is registered in the
// result or skid register. Forwarded bytes run one stream byte behind:
// the final byte of a frame is released by the channel byte of the next
// frame. Throughput is one beat per cycle while the skid entry is free;
// the fade multiply feeds the level and the pixel multiply the held byte.
// A two-entry output stage (result register plus skid register) lets the
// block keep accepting while the receiver stalls; in_ready_o drops only
// once both entries are full. Reset clears the frame state, sets the fade
// level to zero, the target to full brightness, power on, and the base
// and current rates to 30. cfg_we_i writes the base frame rate at once.
`default_nettype none

module pixel_stream_brightness_fader #(
  parameter int unsigned LEVEL_FRAC_BITS = psbf_pkg::LevelFracBitsDefault,
  parameter int unsigned LENGTH_BITS     = psbf_pkg::LengthBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write.
  input  wire logic                          cfg_we_i,
  input  wire logic [psbf_pkg::BaseW-1:0]    cfg_wdata_i,
  // Input channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic [psbf_pkg::ByteW-1:0]    stream_byte_i,
  input  wire logic [psbf_pkg::KeyW-1:0]     key_code_i,
  // Output channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               result_kind_o,
  output logic [psbf_pkg::ByteW-1:0]         out_byte_o,
  output logic                               frame_end_o,
  output logic [psbf_pkg::TargetW-1:0]       target_level_o,
  output logic [psbf_pkg::RateW-1:0]         current_rate_o
);
  import psbf_pkg::*;

  // Level arithmetic: levels are unsigned with 2^F meaning 1.0.
  localparam int unsigned LevelW    = LEVEL_FRAC_BITS + 1;
  localparam longint      LvlOneI   = longint'(1) << LEVEL_FRAC_BITS;
  localparam longint      RateOnI   = (LvlOneI * 3 + 50) / 100;
  localparam longint      RateOffI  = (LvlOneI * 2 + 50) / 100;
  localparam longint      StepI     = (LvlOneI + 50) / 100;
  localparam longint      MinTgtI   = (LvlOneI * 2 + 5) / 10;
  localparam int unsigned DiffW     = LevelW + 1;
  localparam int unsigned ProdW     = DiffW + LevelW;
  localparam int unsigned PixW      = ByteW + LevelW;
  localparam int unsigned WideW     = 32;

  localparam logic [LevelW-1:0] LvlOne  = LevelW'(LvlOneI);
  localparam logic [LevelW-1:0] RateOn  = LevelW'(RateOnI);
  localparam logic [LevelW-1:0] RateOff = LevelW'(RateOffI);
  localparam logic [LevelW-1:0] Step    = LevelW'(StepI);
  localparam logic [LevelW-1:0] MinTgt  = LevelW'(MinTgtI);

  // Frame and fader state.
  phase_e                  phase_q, phase_d;
  logic [ByteW-1:0]        chan_q, chan_d;
  logic [ByteW-1:0]        len_hi_q, len_hi_d;
  logic [LENGTH_BITS-1:0]  bytes_left_q, bytes_left_d;
  logic                    pass_q, pass_d;
  logic [LevelW-1:0]       level_q, level_d;
  logic [LevelW-1:0]       target_q, target_d;
  logic                    power_q, power_d;
  logic [RateW-1:0]        rate_q, rate_d;
  logic [BaseW-1:0]        base_q;

  // One-byte holding register for the forwarded stream.
  logic                    hold_valid_q, hold_valid_d;
  logic [ByteW-1:0]        hold_byte_q, hold_byte_d;
  logic                    hold_end_q, hold_end_d;

  // Output stages.
  result_t                 out_q, skid_q, res;
  logic                    out_valid_q, skid_valid_q;
  logic                    produce;
  logic                    in_fire;
  logic                    out_free;

  // Arithmetic helpers.
  logic [15:0]             len_full;
  logic [LENGTH_BITS-1:0]  len;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] on_prod;
  logic signed [ProdW-1:0] on_step;
  logic [ProdW-1:0]        off_prod;
  logic [PixW-1:0]         pix_prod;
  logic [ByteW-1:0]        scaled;
  logic [LevelW-1:0]       moved;
  logic [LevelW:0]         tgt_up;
  logic [LevelW:0]         tgt_dn;
  logic [RateW:0]          rate_x2;
  logic [RateW:0]          base_x3;
  logic [RateW:0]          base_x1;
  logic [WideW-1:0]        target_wide;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Length of the frame from the stored high byte and the current byte.
  assign len_full = {len_hi_q, stream_byte_i};
  assign len      = len_full[LENGTH_BITS-1:0];

  // Fade step: toward the target with power on, decay with power off.
  assign diff     = $signed({1'b0, target_q}) - $signed({1'b0, level_q});
  assign on_prod  = ProdW'(diff) * $signed({1'b0, RateOn});
  assign on_step  = on_prod >>> LEVEL_FRAC_BITS;
  assign off_prod = ProdW'(level_q) * ProdW'(RateOff);
  assign moved    = power_q ? LevelW'(ProdW'(level_q) + on_step)
                            : LevelW'(ProdW'(level_q) - (off_prod >> LEVEL_FRAC_BITS));

  // Pixel scaling by the current fade level.
  assign pix_prod = PixW'(stream_byte_i) * PixW'(level_q);
  assign scaled   = pix_prod[LEVEL_FRAC_BITS +: ByteW];

  // Target and rate steps for the key events.
  assign tgt_up  = {1'b0, target_q} + {1'b0, Step};
  assign tgt_dn  = {1'b0, target_q} - {1'b0, Step};
  assign rate_x2 = {rate_q, 1'b0};
  assign base_x1 = (RateW+1)'(base_q);
  assign base_x3 = (base_x1 << 1) + base_x1;

  // Next state and the result of the accepted beat.
  always_comb begin
    phase_d      = phase_q;
    chan_d       = chan_q;
    len_hi_d     = len_hi_q;
    bytes_left_d = bytes_left_q;
    pass_d       = pass_q;
    level_d      = level_q;
    target_d     = target_q;
    power_d      = power_q;
    rate_d       = rate_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    hold_end_d   = hold_end_q;
    produce      = 1'b0;
    res          = '0;
    res.kind     = KindByte;
    res.data     = hold_byte_q;
    res.frame_end = hold_end_q;
    target_wide  = '0;

    if (in_fire) begin
      if (mode_i == ModeKey) begin
        case (key_e'(key_code_i))
          KEY_OFF: power_d = 1'b0;
          KEY_ON:  power_d = 1'b1;
          KEY_RESET: begin
            rate_d   = RateW'(base_q);
            target_d = LvlOne;
          end
          KEY_FASTER: begin
            if (rate_x2 < base_x3) begin
              rate_d = rate_q + 1'b1;
            end
          end
          KEY_SLOWER: begin
            if (rate_x2 > base_x1) begin
              rate_d = rate_q - 1'b1;
            end
          end
          KEY_BRIGHTER: begin
            target_d = (tgt_up > {1'b0, LvlOne}) ? LvlOne : tgt_up[LevelW-1:0];
          end
          KEY_DIMMER: begin
            target_d = (tgt_dn < {1'b0, MinTgt}) ? MinTgt : tgt_dn[LevelW-1:0];
          end
          default: ;
        endcase
        target_wide   = WideW'(target_d);
        produce       = 1'b1;
        res.kind      = KindStatus;
        res.data      = '0;
        res.frame_end = 1'b0;
        res.target    = target_wide[TargetW-1:0];
        res.rate      = rate_d;
      end else begin
        case (phase_q)
          HDR_CHAN: begin
            // The channel byte releases the last byte of the previous frame.
            chan_d       = stream_byte_i;
            phase_d      = HDR_CMD;
            produce      = hold_valid_q;
            hold_valid_d = 1'b0;
          end
          HDR_CMD: begin
            // Only a zero command passes the frame; the channel byte goes out now.
            pass_d  = (stream_byte_i == '0);
            phase_d = HDR_LEN_HI;
            if (stream_byte_i == '0) begin
              produce       = 1'b1;
              res.data      = chan_q;
              res.frame_end = 1'b0;
              hold_valid_d  = 1'b1;
              hold_byte_d   = stream_byte_i;
              hold_end_d    = 1'b0;
            end
          end
          HDR_LEN_HI: begin
            len_hi_d = stream_byte_i;
            phase_d  = HDR_LEN_LO;
            if (pass_q) begin
              produce      = hold_valid_q;
              hold_valid_d = 1'b1;
              hold_byte_d  = stream_byte_i;
              hold_end_d   = 1'b0;
            end
          end
          HDR_LEN_LO: begin
            bytes_left_d = len;
            phase_d      = (len != '0) ? HDR_DATA : HDR_CHAN;
            if (pass_q) begin
              level_d      = moved;
              produce      = hold_valid_q;
              hold_valid_d = 1'b1;
              hold_byte_d  = stream_byte_i;
              hold_end_d   = (len == '0);
            end
          end
          HDR_DATA: begin
            bytes_left_d = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : '0;
            if (bytes_left_q <= LENGTH_BITS'(1)) begin
              phase_d = HDR_CHAN;
            end
            if (pass_q) begin
              produce      = hold_valid_q;
              hold_valid_d = 1'b1;
              hold_byte_d  = scaled;
              hold_end_d   = (bytes_left_q <= LENGTH_BITS'(1));
            end
          end
          default: phase_d = HDR_CHAN;
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= HDR_CHAN;
      chan_q       <= '0;
      len_hi_q     <= '0;
      bytes_left_q <= '0;
      pass_q       <= 1'b0;
      level_q      <= '0;
      target_q     <= LvlOne;
      power_q      <= 1'b1;
      rate_q       <= RateW'(BaseRateReset);
      base_q       <= BaseRateReset;
      hold_valid_q <= 1'b0;
      hold_end_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      chan_q       <= chan_d;
      len_hi_q     <= len_hi_d;
      bytes_left_q <= bytes_left_d;
      pass_q       <= pass_d;
      level_q      <= level_d;
      target_q     <= target_d;
      power_q      <= power_d;
      rate_q       <= rate_d;
      hold_valid_q <= hold_valid_d;
      hold_end_q   <= hold_end_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  // The held byte itself carries no reset.
  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads follow the same moves as the valid bits.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (produce) begin
        out_q <= res;
      end
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign out_byte_o     = out_q.data;
  assign frame_end_o    = out_q.frame_end;
  assign target_level_o = out_q.target;
  assign current_rate_o = out_q.rate;

endmodule

`default_nettype wire

// ----- test/psbf_checker.sv -----
// Checker for the pixel stream brightness fader: predicts every result beat and compares it.
`timescale 1ns / 1ps

module psbf_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [psbf_pkg::BaseW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       mode_i,
  input  wire logic [psbf_pkg::ByteW-1:0] stream_byte_i,
  input  wire logic [psbf_pkg::KeyW-1:0]  key_code_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic                       result_kind_i,
  input  wire logic [psbf_pkg::ByteW-1:0] out_byte_i,
  input  wire logic                       frame_end_i,
  input  wire logic [psbf_pkg::TargetW-1:0] target_level_i,
  input  wire logic [psbf_pkg::RateW-1:0] current_rate_i,
  output int                              fail_count_o,
  output int                              results_waiting_o
);
  import psbf_pkg::*;

  // Fade arithmetic in unsigned Q.F, with the constants rounded to nearest.
  localparam int     FracBits    = LevelFracBitsDefault;
  localparam longint LevelOne    = 64'sd1 << FracBits;
  localparam longint RiseGain    = (LevelOne * 3 + 50) / 100;
  localparam longint DecayGain   = (LevelOne * 2 + 50) / 100;
  localparam longint TargetStep  = (LevelOne + 50) / 100;
  localparam longint TargetFloor = (LevelOne * 2 + 5) / 10;

  // Predicted state of the fader.
  phase_e             frame_phase;
  logic [ByteW-1:0]   chan_byte;
  logic [ByteW-1:0]   len_hi_byte;
  logic [15:0]        bytes_left;
  logic               pass_frame;
  logic               power_on;
  longint             fade_level;
  longint             fade_target;
  logic [RateW-1:0]   rate_now;
  logic [BaseW-1:0]   base_rate;

  // The forwarded byte that runs one stream beat behind.
  logic               held_valid;
  logic [ByteW-1:0]   held_byte;
  logic               held_end;

  result_t            results_due[$];

  // Releases the held byte as a result beat, if there is one, and holds the new one.
  task automatic release_held(input logic put, input logic [ByteW-1:0] value, input logic last);
    result_t fwd;
    if (held_valid) begin
      fwd           = '0;
      fwd.kind      = KindByte;
      fwd.data      = held_byte;
      fwd.frame_end = held_end;
      results_due.push_back(fwd);
    end
    held_valid = put;
    held_byte  = value;
    held_end   = last;
  endtask

  // Works out the effect of one accepted input beat.
  task automatic step_fader(input logic mode, input logic [ByteW-1:0] sbyte,
                            input logic [KeyW-1:0] key);
    result_t     status;
    logic [15:0] frame_len;
    logic        last;
    longint      scaled;
    if (mode == ModeKey) begin
      case (key)
        KEY_OFF:    power_on = 1'b0;
        KEY_ON:     power_on = 1'b1;
        KEY_RESET: begin
          rate_now    = RateW'(base_rate);
          fade_target = LevelOne;
        end
        KEY_FASTER: if (2 * rate_now < 3 * base_rate) rate_now = rate_now + 1'b1;
        KEY_SLOWER: if (2 * rate_now > base_rate) rate_now = rate_now - 1'b1;
        KEY_BRIGHTER: begin
          fade_target = fade_target + TargetStep;
          if (fade_target > LevelOne) fade_target = LevelOne;
        end
        KEY_DIMMER: begin
          fade_target = fade_target - TargetStep;
          if (fade_target < TargetFloor) fade_target = TargetFloor;
        end
        default: ;
      endcase
      status        = '0;
      status.kind   = KindStatus;
      status.target = fade_target[TargetW-1:0];
      status.rate   = rate_now;
      results_due.push_back(status);
    end else begin
      case (frame_phase)
        HDR_CHAN: begin
          // The channel byte flushes the last byte of the previous frame.
          chan_byte   = sbyte;
          frame_phase = HDR_CMD;
          release_held(1'b0, '0, 1'b0);
        end
        HDR_CMD: begin
          pass_frame  = (sbyte == '0);
          frame_phase = HDR_LEN_HI;
          if (pass_frame) begin
            held_valid = 1'b1;
            held_byte  = chan_byte;
            held_end   = 1'b0;
            release_held(1'b1, sbyte, 1'b0);
          end
        end
        HDR_LEN_HI: begin
          len_hi_byte = sbyte;
          frame_phase = HDR_LEN_LO;
          if (pass_frame) release_held(1'b1, sbyte, 1'b0);
        end
        HDR_LEN_LO: begin
          frame_len   = {len_hi_byte, sbyte};
          bytes_left  = frame_len;
          frame_phase = (frame_len != '0) ? HDR_DATA : HDR_CHAN;
          if (pass_frame) begin
            // The fade level moves once per forwarded header.
            if (power_on)
              fade_level = fade_level + (((fade_target - fade_level) * RiseGain) >>> FracBits);
            else
              fade_level = fade_level - ((fade_level * DecayGain) >>> FracBits);
            release_held(1'b1, sbyte, frame_len == '0);
          end
        end
        default: begin
          last   = (bytes_left <= 1);
          scaled = (longint'(sbyte) * fade_level) >>> FracBits;
          if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
          if (last) frame_phase = HDR_CHAN;
          if (pass_frame) release_held(1'b1, scaled[ByteW-1:0], last);
        end
      endcase
    end
  endtask

  function automatic void flag_mismatch(string field, longint want, longint got);
    fail_count_o = fail_count_o + 1;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Compares one accepted result beat with the oldest expectation.
  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      fail_count_o = fail_count_o + 1;
      $display("%0t: result beat with none expected, got kind %0d byte %0d end %0d target %0d rate %0d",
               $time, result_kind_i, out_byte_i, frame_end_i, target_level_i, current_rate_i);
    end else begin
      want = results_due.pop_front();
      if (want.kind != result_kind_i) flag_mismatch("result_kind", want.kind, result_kind_i);
      if (want.data != out_byte_i) flag_mismatch("out_byte", want.data, out_byte_i);
      if (want.frame_end != frame_end_i) flag_mismatch("frame_end", want.frame_end, frame_end_i);
      if (want.target != target_level_i)
        flag_mismatch("target_level", want.target, target_level_i);
      if (want.rate != current_rate_i) flag_mismatch("current_rate", want.rate, current_rate_i);
    end
  endtask

  // Results leaving at an edge never stem from the beat accepted at that edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase  = HDR_CHAN;
      chan_byte    = '0;
      len_hi_byte  = '0;
      bytes_left   = '0;
      pass_frame   = 1'b0;
      power_on     = 1'b1;
      fade_level   = 0;
      fade_target  = LevelOne;
      base_rate    = BaseRateReset;
      rate_now     = RateW'(BaseRateReset);
      held_valid   = 1'b0;
      held_byte    = '0;
      held_end     = 1'b0;
      results_due.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) step_fader(mode_i, stream_byte_i, key_code_i);
      if (cfg_we_i) base_rate = cfg_wdata_i;
    end
    results_waiting_o = results_due.size();
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the pixel stream brightness fader: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb;
  import psbf_pkg::*;

  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 16;
  localparam int PhaseBeats  = 480;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [BaseW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic mode = ModeStream;
  logic [ByteW-1:0] sbyte = '0;
  logic [KeyW-1:0] key = KEY_OFF;
  logic out_ready = 1'b0;

  wire logic in_ready;
  wire logic out_valid;
  wire logic result_kind;
  wire logic [ByteW-1:0] out_byte;
  wire logic frame_end;
  wire logic [TargetW-1:0] target_level;
  wire logic [RateW-1:0] current_rate;

  int fail_count;
  int results_waiting;
  int stall_run = 0;
  int beats_sent = 0;
  bit quiet = 1'b0;

  // Where the sent stream stands in its frame, so that broken frames can be closed off.
  int frame_pos = 0;
  logic [15:0] data_owed = '0;
  logic [ByteW-1:0] len_hi_sent = '0;

  pixel_stream_brightness_fader u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .stream_byte_i  (sbyte),
    .key_code_i     (key),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .out_byte_o     (out_byte),
    .frame_end_o    (frame_end),
    .target_level_o (target_level),
    .current_rate_o (current_rate)
  );

  psbf_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .mode_i            (mode),
    .stream_byte_i     (sbyte),
    .key_code_i        (key),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_i     (result_kind),
    .out_byte_i        (out_byte),
    .frame_end_i       (frame_end),
    .target_level_i    (target_level),
    .current_rate_i    (current_rate),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver stalls now and then, except during the quiet stretch.
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 12);
  end

  // Watchdog: ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run <= 0;
    end else begin
      stall_run <= stall_run + 1;
      if (stall_run >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one input beat, with an occasional gap before it, and waits for its acceptance.
  task automatic send_beat(input logic m, input logic [ByteW-1:0] b, input logic [KeyW-1:0] k,
                           input bit counted);
    if (!quiet && $urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    sbyte    <= b;
    key      <= k;
    do @(posedge clk); while (!in_ready);
    if (counted) beats_sent++;
  endtask

  task automatic send_key(input logic [KeyW-1:0] k);
    send_beat(ModeKey, ByteW'($urandom), k, 1'b1);
  endtask

  task automatic send_stream(input logic [ByteW-1:0] b, input bit counted);
    send_beat(ModeStream, b, KeyW'($urandom), counted);
    case (frame_pos)
      0, 1: frame_pos++;
      2: begin
        len_hi_sent = b;
        frame_pos   = 3;
      end
      3: begin
        data_owed = {len_hi_sent, b};
        frame_pos = (data_owed != '0) ? 4 : 0;
      end
      default: begin
        data_owed = data_owed - 1'b1;
        if (data_owed == '0) frame_pos = 0;
      end
    endcase
  endtask

  // A random byte that keeps any length it lands in short.
  function automatic logic [ByteW-1:0] tame_byte();
    if (frame_pos == 2) return '0;
    if (frame_pos == 3) return ByteW'($urandom_range(0, 15));
    return ByteW'($urandom);
  endfunction

  task automatic send_frame(input logic [ByteW-1:0] chan, input logic [ByteW-1:0] cmd,
                            input logic [15:0] len, input bit mixed);
    send_stream(chan, 1'b1);
    send_stream(cmd, 1'b1);
    send_stream(len[15:8], 1'b1);
    send_stream(len[7:0], 1'b1);
    for (int i = 0; i < len; i++) begin
      if (mixed && $urandom_range(99) < 8) send_key(KeyW'($urandom));
      send_stream(ByteW'($urandom), 1'b1);
    end
  endtask

  // Holds the sender back until every expected result has left the block.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [BaseW-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed frames and key runs, with some broken frames mixed in.
  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [ByteW-1:0] cmd;
    logic [15:0] len;
    logic [KeyW-1:0] run_key;
    int unsigned run_len;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        cmd = ($urandom_range(99) < 80) ? 8'h00 : ByteW'($urandom);
        if ($urandom_range(99) < 2) len = 16'($urandom_range(256, 264));
        else len = 16'($urandom_range(0, 10));
        send_frame(ByteW'($urandom), cmd, len, $urandom_range(99) < 30);
      end else if (pick < 90) begin
        // Long key runs reach the saturation points of target and rate.
        run_key = KeyW'($urandom);
        run_len = ($urandom_range(99) < 85) ? 1 : $urandom_range(2, 130);
        repeat (run_len) send_key(run_key);
      end else begin
        repeat ($urandom_range(1, 3)) send_stream(tame_byte(), 1'b1);
        while (frame_pos != 0) send_stream(tame_byte(), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset base rate.
    send_key(KEY_OTHER);
    // Passed frame of two data bytes at the byte extremes.
    send_stream(8'hFF, 1'b1);
    send_stream(8'h00, 1'b1);
    send_stream(8'h00, 1'b1);
    send_stream(8'h02, 1'b1);
    send_stream(8'hFF, 1'b1);
    send_stream(8'h00, 1'b1);
    // Dropped frame; its channel byte still flushes the previous last byte.
    send_stream(8'h00, 1'b0);
    send_stream(8'h80, 1'b0);
    send_stream(8'h00, 1'b0);
    send_stream(8'h01, 1'b0);
    send_stream(8'hAA, 1'b0);
    // Empty frame, whose length byte stays held while the keys below go by.
    send_stream(8'h5A, 1'b1);
    send_stream(8'h00, 1'b1);
    send_stream(8'h00, 1'b1);
    send_stream(8'h00, 1'b1);
    send_key(KEY_OFF);
    send_key(KEY_ON);
    send_key(KEY_RESET);
    send_key(KEY_FASTER);
    send_key(KEY_SLOWER);
    send_key(KEY_BRIGHTER);
    send_key(KEY_DIMMER);
    send_key(KEY_OTHER);

    // Random phases over several base rates, the extremes among them.
    write_base(8'd1);
    send_key(KEY_RESET);
    random_phase(PhaseBeats);

    write_base(8'd255);
    send_key(KEY_RESET);
    quiet = 1'b1;
    random_phase(PhaseBeats);
    quiet = 1'b0;

    write_base(BaseW'($urandom_range(2, 254)));
    send_key(KEY_RESET);
    random_phase(PhaseBeats);

    // No reset key here: the rate keeps its old value until one comes.
    write_base(BaseRateReset);
    random_phase(PhaseBeats);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
